// File: hdl/utf8_to_utf16_bounded_transcoder_unit_macros.svh
// Assertion macros for the UTF-8 to UTF-16 transcoder.
`ifndef UTF8_TO_UTF16_BOUNDED_TRANSCODER_UNIT_MACROS_SVH
`define UTF8_TO_UTF16_BOUNDED_TRANSCODER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define U8U16_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("u8u16 check failed");

// next-cycle implication, disabled in reset
`define U8U16_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("u8u16 check failed");

`endif

// File: hdl/u8u16_pkg.sv
// Types and constants shared by the UTF-8 to UTF-16 transcoder.
`default_nettype none
package u8u16_pkg;

    localparam int unsigned MAX_CAPACITY = 4096;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned UNIT_W       = 16;
    localparam int unsigned CNT_W        = 13;
    localparam int unsigned POINT_W      = 21;
    localparam int unsigned PEND_W       = 2;
    localparam int unsigned RES_SLOTS    = 3;
    localparam int unsigned SLOT_W       = 2;
    localparam int unsigned QDEPTH       = 4;
    localparam int unsigned QPTR_W       = 2;
    localparam int unsigned QLVL_W       = 3;

    localparam int unsigned CNT_MAX      = (1 << CNT_W) - 1;
    localparam logic [CNT_W-1:0] LIMIT_CAP =
        (MAX_CAPACITY > CNT_MAX) ? CNT_W'(CNT_MAX) : CNT_W'(MAX_CAPACITY);
    localparam logic [CNT_W-1:0]   MAX_UNITS_RST = 13'd4096;
    localparam logic [UNIT_W-1:0]  HI_SURR       = 16'hD800;
    localparam logic [UNIT_W-1:0]  LO_SURR       = 16'hDC00;
    localparam logic [POINT_W-1:0] PAIR_BASE     = 21'h10000;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              has_byte;
        logic              end_of_text;
    } t_item;

    typedef struct packed {
        logic [POINT_W-1:0] partial_point;
        logic [PEND_W-1:0]  bytes_pending;
        logic [CNT_W-1:0]   unit_count;
        logic               halted;
    } t_state;

    typedef struct packed {
        logic [UNIT_W-1:0] code_unit;
        logic [CNT_W-1:0]  unit_index;
        logic              is_terminator;
        logic [CNT_W-1:0]  units_written;
        logic              last_result;
    } t_result;

    typedef struct packed {
        logic [QLVL_W-1:0] level;
        logic              room;
    } t_q_status;

endpackage
`default_nettype wire

// File: hdl/u8u16_step.sv
// Per-byte decode: next state and up to three results for one input item.
`default_nettype none
module u8u16_step (
    input  wire u8u16_pkg::t_state          i_state,
    input  wire u8u16_pkg::t_item           i_item,
    input  wire [u8u16_pkg::CNT_W-1:0]      i_limit,
    output u8u16_pkg::t_state               o_state,
    output u8u16_pkg::t_result              o_res [u8u16_pkg::RES_SLOTS],
    output logic [u8u16_pkg::SLOT_W-1:0]    o_count
);

    always_comb begin
        logic [u8u16_pkg::POINT_W-1:0] pt;
        logic [u8u16_pkg::POINT_W-1:0] v;
        logic                          emit;
        logic [u8u16_pkg::BYTE_W-1:0]  c;
        logic [u8u16_pkg::SLOT_W-1:0]  k;

        o_state = i_state;
        for (int i = 0; i < int'(u8u16_pkg::RES_SLOTS); i++) begin
            o_res[i] = '0;
        end
        k    = '0;
        emit = 1'b0;
        pt   = '0;
        v    = '0;
        c    = i_item.text_byte;

        if (i_item.has_byte && !i_state.halted) begin
            if (i_state.bytes_pending != '0) begin
                o_state.partial_point = {i_state.partial_point[14:0], c[5:0]};
                o_state.bytes_pending = i_state.bytes_pending - 2'd1;
                if (o_state.bytes_pending == '0) begin
                    emit = 1'b1;
                    pt   = o_state.partial_point;
                end
            end else if (i_state.unit_count >= i_limit) begin
                o_state.halted = 1'b1;
            end else if (!c[7]) begin
                emit = 1'b1;
                pt   = {13'b0, c};
            end else if (c[7:5] == 3'b110) begin
                o_state.partial_point = {16'b0, c[4:0]};
                o_state.bytes_pending = 2'd1;
            end else if (c[7:4] == 4'b1110) begin
                o_state.partial_point = {17'b0, c[3:0]};
                o_state.bytes_pending = 2'd2;
            end else if (c[7:3] == 5'b11110) begin
                o_state.partial_point = {18'b0, c[2:0]};
                o_state.bytes_pending = 2'd3;
            end
        end

        if (emit) begin
            if (pt[20:16] == '0) begin
                o_res[0].code_unit  = pt[15:0];
                o_res[0].unit_index = o_state.unit_count;
                o_state.unit_count  = o_state.unit_count + 13'd1;
                k = 2'd1;
            end else if (({1'b0, o_state.unit_count} + 14'd2) > {1'b0, i_limit}) begin
                o_state.halted = 1'b1;
            end else begin
                v = pt - u8u16_pkg::PAIR_BASE;
                o_res[0].code_unit  = u8u16_pkg::HI_SURR | {5'b0, v[20:10]};
                o_res[0].unit_index = o_state.unit_count;
                o_res[1].code_unit  = u8u16_pkg::LO_SURR | {6'b0, v[9:0]};
                o_res[1].unit_index = o_state.unit_count + 13'd1;
                o_state.unit_count  = o_state.unit_count + 13'd2;
                k = 2'd2;
            end
        end

        if (i_item.end_of_text) begin
            o_res[k].code_unit     = '0;
            o_res[k].unit_index    = o_state.unit_count;
            o_res[k].is_terminator = 1'b1;
            o_res[k].units_written = o_state.unit_count;
            o_state = '0;
            k = k + 2'd1;
        end

        if (k != '0) begin
            o_res[k - 2'd1].last_result = 1'b1;
        end
        o_count = k;
    end

endmodule
`default_nettype wire

// File: hdl/u8u16_resq.sv
// Four-entry result queue: pushes up to three results a cycle, pops one.
`default_nettype none
module u8u16_resq (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire u8u16_pkg::t_result          i_res [u8u16_pkg::RES_SLOTS],
    input  wire [u8u16_pkg::SLOT_W-1:0]      i_push_cnt,
    input  wire                              i_ready,
    output logic                             o_valid,
    output u8u16_pkg::t_result               o_res,
    output u8u16_pkg::t_q_status             o_status
);

    u8u16_pkg::t_result               r_mem [u8u16_pkg::QDEPTH];
    logic [u8u16_pkg::QPTR_W-1:0]     r_wr, r_rd;
    logic [u8u16_pkg::QLVL_W-1:0]     r_level;
    logic                             pop;

    function automatic logic [u8u16_pkg::SLOT_W-1:0] SLOT_W_EXT(input int idx);
        return u8u16_pkg::SLOT_W'(idx);
    endfunction

    assign o_valid = (r_level != '0);
    assign pop     = o_valid && i_ready;
    assign o_res   = r_mem[r_rd];

    assign o_status.level = r_level;
    assign o_status.room  = (r_level - {2'b0, pop}) <= 3'd1;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < int'(u8u16_pkg::RES_SLOTS); i++) begin
            if (SLOT_W_EXT(i) < i_push_cnt) begin
                r_mem[r_wr + u8u16_pkg::QPTR_W'(i)] <= i_res[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            r_wr    <= r_wr + i_push_cnt;
            r_rd    <= r_rd + {1'b0, pop};
            r_level <= r_level + {1'b0, i_push_cnt} - {2'b0, pop};
        end
    end

endmodule
`default_nettype wire

// File: hdl/utf8_to_utf16_bounded_transcoder_unit.sv
// Streaming UTF-8 to UTF-16 transcoder with a configurable unit limit.
// Accepts one UTF-8 byte per cycle when the queue has room. Each byte is
// registered, decoded combinationally, and its results (one code unit, a
// surrogate pair, and/or the terminator) are pushed into a four-entry result
// queue that drains one result per cycle while the output is ready. Input is
// taken whenever the queue has room for three results; the queue absorbs one
// extra result (pair or terminator) without a stall, and while that backlog
// stands each further extra result holds input until the queue drains an
// entry if the output side keeps pace. The limit register may be written only
// while no string is in flight; the terminator result resets all string state.
`default_nettype none
`include "utf8_to_utf16_bounded_transcoder_unit_macros.svh"
module utf8_to_utf16_bounded_transcoder_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // text_byte
    input  wire         i_s_axis_tuser,   // has_byte
    input  wire         i_s_axis_tlast,   // end_of_text
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // code_unit, unit_index, units_written, pad
    output logic        o_m_axis_tuser,   // is_terminator
    output logic        o_m_axis_tlast,   // last_result
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [12:0] i_cfg_data        // max_units
);

    u8u16_pkg::t_item               r_in;
    logic                           r_in_valid;
    u8u16_pkg::t_state              r_state;
    logic [u8u16_pkg::CNT_W-1:0]    r_max_units;

    u8u16_pkg::t_state              n_state;
    u8u16_pkg::t_result             step_res [u8u16_pkg::RES_SLOTS];
    logic [u8u16_pkg::SLOT_W-1:0]   step_cnt;
    logic [u8u16_pkg::SLOT_W-1:0]   push_cnt;
    logic [u8u16_pkg::CNT_W-1:0]    limit;
    u8u16_pkg::t_result             q_res;
    u8u16_pkg::t_q_status           q_status;
    logic                           fire;
    logic                           in_xfer;

    assign o_cfg_ready     = 1'b1;
    assign fire            = r_in_valid && q_status.room;
    assign o_s_axis_tready = !r_in_valid || fire;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign push_cnt        = fire ? step_cnt : '0;
    assign limit           = (r_max_units < u8u16_pkg::LIMIT_CAP) ? r_max_units
                                                                  : u8u16_pkg::LIMIT_CAP;

    u8u16_step u_step (
        .i_state (r_state),
        .i_item  (r_in),
        .i_limit (limit),
        .o_state (n_state),
        .o_res   (step_res),
        .o_count (step_cnt)
    );

    u8u16_resq u_resq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res      (step_res),
        .i_push_cnt (push_cnt),
        .i_ready    (i_m_axis_tready),
        .o_valid    (o_m_axis_tvalid),
        .o_res      (q_res),
        .o_status   (q_status)
    );

    assign o_m_axis_tdata = {6'b0, q_res.units_written, q_res.unit_index, q_res.code_unit};
    assign o_m_axis_tuser = q_res.is_terminator;
    assign o_m_axis_tlast = q_res.last_result;

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in.text_byte   <= i_s_axis_tdata;
            r_in.has_byte    <= i_s_axis_tuser;
            r_in.end_of_text <= i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_state     <= '0;
            r_max_units <= u8u16_pkg::MAX_UNITS_RST;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_state <= n_state;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_units <= i_cfg_data;
            end
        end
    end

    `U8U16_ASSERT_NOW(a_valid_tracks_queue, i_clk, i_rst_n, 1'b1,
        o_m_axis_tvalid == (q_status.level != '0))
    `U8U16_ASSERT_NEXT(a_string_end_clears, i_clk, i_rst_n, fire && r_in.end_of_text,
        r_state == '0)
    `U8U16_ASSERT_NEXT(a_halt_freezes_count, i_clk, i_rst_n,
        r_state.halted && !(fire && r_in.end_of_text),
        r_state.unit_count == $past(r_state.unit_count))
    `U8U16_ASSERT_NOW(a_queue_bounded, i_clk, i_rst_n, 1'b1, q_status.level <= 3'd4)

endmodule
`default_nettype wire
